// ===== design/cske_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the clock setting key editor.
// Used by cske_step and clock_setting_key_editor_top; depends on nothing.
package cske_pkg;

   // Key codes.
   localparam logic [1:0] ActDecrease = 2'd0;
   localparam logic [1:0] ActNext     = 2'd1;
   localparam logic [1:0] ActIncrease = 2'd2;
   localparam logic [1:0] ActUp       = 2'd3;

   // Display mode codes.
   localparam logic [2:0] ModeStopwatch = 3'd0;
   localparam logic [2:0] ModeTimeSet   = 3'd1;
   localparam logic [2:0] ModeDateSet   = 3'd2;
   localparam logic [2:0] ModeZoneSet   = 3'd3;
   localparam logic [2:0] ModeAlarmSet  = 3'd4;
   localparam logic [2:0] ModeSoundSet  = 3'd5;
   localparam logic [2:0] ModeRinging   = 3'd6;
   localparam logic [2:0] ModeOther     = 3'd7;

   // Changed item codes.
   localparam logic [3:0] ItemNone        = 4'd0;
   localparam logic [3:0] ItemHour        = 4'd1;
   localparam logic [3:0] ItemMinute      = 4'd2;
   localparam logic [3:0] ItemSecond      = 4'd3;
   localparam logic [3:0] ItemYear        = 4'd4;
   localparam logic [3:0] ItemMonth       = 4'd5;
   localparam logic [3:0] ItemDay         = 4'd6;
   localparam logic [3:0] ItemZone        = 4'd7;
   localparam logic [3:0] ItemAlarmHour   = 4'd8;
   localparam logic [3:0] ItemAlarmMinute = 4'd9;
   localparam logic [3:0] ItemAlarmEnable = 4'd10;
   localparam logic [3:0] ItemSound       = 4'd11;
   localparam logic [3:0] ItemStopwatch   = 4'd12;
   localparam logic [3:0] ItemCursor      = 4'd13;

   // Commit codes.
   localparam logic [2:0] CommitNone  = 3'd0;
   localparam logic [2:0] CommitClock = 3'd1;
   localparam logic [2:0] CommitAlarm = 3'd2;
   localparam logic [2:0] CommitZone  = 3'd3;
   localparam logic [2:0] CommitSound = 3'd4;

   // Cursor positions.
   localparam logic [1:0] CurFirst  = 2'd0;
   localparam logic [1:0] CurSecond = 2'd1;
   localparam logic [1:0] CurThird  = 2'd2;

   // Value limits.
   localparam logic [4:0]  HourTop   = 5'd23;
   localparam logic [5:0]  MinuteTop = 6'd59;
   localparam logic [13:0] YearMin   = 14'd1970;
   localparam logic [13:0] YearMax   = 14'd9999;
   localparam logic [3:0]  MonthMax  = 4'd12;
   localparam logic signed [4:0] ZoneMin = -5'sd12;
   localparam logic signed [4:0] ZoneMax = 5'sd12;

   // Floor(year / 100) as (year * YearDivMul) >> YearDivShift, exact for 14-bit years.
   localparam logic [12:0] YearDivMul   = 13'd5243;
   localparam int          YearDivShift = 19;

   // Kept settings.
   typedef struct packed {
      logic [4:0]        set_hour;
      logic [5:0]        set_minute;
      logic [5:0]        set_second;
      logic [13:0]       set_year;
      logic [3:0]        set_month;
      logic [4:0]        set_day;
      logic [1:0]        time_cursor;
      logic [1:0]        date_cursor;
      logic [1:0]        alarm_cursor;
      logic signed [4:0] zone_offset;
      logic [4:0]        alarm_hour;
      logic [5:0]        alarm_minute;
      logic              alarm_enable;
      logic              sound_enable;
      logic              stopwatch_enable;
   } state_type;

   // Power-up settings: 00:00:00 on 1970-01-01, everything else zero.
   localparam state_type StateReset = '{set_year:  YearMin,
                                        set_month: 4'd1,
                                        set_day:   5'd1,
                                        default:   '0};

   // One result item.
   typedef struct packed {
      logic [3:0]         changed_item;
      logic signed [14:0] new_value;
      logic [1:0]         cursor;
      logic               beep;
      logic               stopwatch_clear;
      logic               alarm_release;
      logic               alarm_suppress;
      logic               next_row;
      logic [2:0]         commit;
   } result_type;

endpackage

// ===== design/cske_step.sv =====
`timescale 1ns / 1ps
// Combinational key press evaluation: next settings and one result item.
// Depends on cske_pkg.
module cske_step (
   input  cske_pkg::state_type  cur_state,
   input  logic [1:0]           action,
   input  logic [2:0]           mode,
   output cske_pkg::state_type  next_state,
   output cske_pkg::result_type result
);

   logic [26:0] year_prod;
   logic [7:0]  year_cent;
   logic [13:0] year_cent_x100;
   logic [13:0] year_rem;
   logic        leap;
   logic [4:0]  month_len;
   logic        inc;

   // Leap year from the century quotient and remainder.
   assign year_prod      = 27'(cur_state.set_year) * 27'(cske_pkg::YearDivMul);
   assign year_cent      = year_prod[26:cske_pkg::YearDivShift];
   assign year_cent_x100 = 14'({6'd0, year_cent} * 14'd100);
   assign year_rem       = cur_state.set_year - year_cent_x100;
   assign leap = ((cur_state.set_year[1:0] == 2'd0) && (year_rem != 14'd0)) ||
                 ((year_rem == 14'd0) && (year_cent[1:0] == 2'd0));

   // Month length; codes outside one to twelve count as thirty days.
   always_comb begin
      case (cur_state.set_month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
         4'd2:    month_len = leap ? 5'd29 : 5'd28;
         default: month_len = 5'd30;
      endcase
   end

   assign inc = (action == cske_pkg::ActIncrease);

   // Key decode per mode.
   always_comb begin
      next_state = cur_state;
      result     = '0;
      result.beep = cur_state.sound_enable;

      if (action == cske_pkg::ActUp) begin
         result.next_row = (mode != cske_pkg::ModeRinging);
      end else begin
         unique case (mode)
            cske_pkg::ModeStopwatch: begin
               if (action == cske_pkg::ActDecrease) begin
                  next_state.stopwatch_enable = 1'b0;
                  result.stopwatch_clear = 1'b1;
                  result.changed_item = cske_pkg::ItemStopwatch;
               end else if (action == cske_pkg::ActNext) begin
                  next_state.stopwatch_enable = ~cur_state.stopwatch_enable;
                  result.changed_item = cske_pkg::ItemStopwatch;
                  result.new_value = 15'(next_state.stopwatch_enable);
               end
            end
            cske_pkg::ModeTimeSet: begin
               if (action == cske_pkg::ActNext) begin
                  next_state.time_cursor = (cur_state.time_cursor >= cske_pkg::CurThird) ?
                                           cske_pkg::CurFirst : cur_state.time_cursor + 2'd1;
                  result.changed_item = cske_pkg::ItemCursor;
                  result.new_value = 15'(next_state.time_cursor);
               end else begin
                  result.commit = cske_pkg::CommitClock;
                  if (cur_state.time_cursor == cske_pkg::CurFirst) begin
                     if (inc)
                        next_state.set_hour = (cur_state.set_hour >= cske_pkg::HourTop) ?
                                              5'd0 : cur_state.set_hour + 5'd1;
                     else
                        next_state.set_hour = (cur_state.set_hour == 5'd0 ||
                                               cur_state.set_hour > cske_pkg::HourTop) ?
                                              cske_pkg::HourTop : cur_state.set_hour - 5'd1;
                     result.changed_item = cske_pkg::ItemHour;
                     result.new_value = 15'(next_state.set_hour);
                  end else if (cur_state.time_cursor == cske_pkg::CurSecond) begin
                     if (inc)
                        next_state.set_minute = (cur_state.set_minute >= cske_pkg::MinuteTop) ?
                                                6'd0 : cur_state.set_minute + 6'd1;
                     else
                        next_state.set_minute = (cur_state.set_minute == 6'd0 ||
                                                 cur_state.set_minute > cske_pkg::MinuteTop) ?
                                                cske_pkg::MinuteTop : cur_state.set_minute - 6'd1;
                     result.changed_item = cske_pkg::ItemMinute;
                     result.new_value = 15'(next_state.set_minute);
                  end else if (cur_state.time_cursor == cske_pkg::CurThird) begin
                     if (inc)
                        next_state.set_second = (cur_state.set_second >= cske_pkg::MinuteTop) ?
                                                6'd0 : cur_state.set_second + 6'd1;
                     else
                        next_state.set_second = (cur_state.set_second == 6'd0 ||
                                                 cur_state.set_second > cske_pkg::MinuteTop) ?
                                                cske_pkg::MinuteTop : cur_state.set_second - 6'd1;
                     result.changed_item = cske_pkg::ItemSecond;
                     result.new_value = 15'(next_state.set_second);
                  end
               end
               result.cursor = next_state.time_cursor;
            end
            cske_pkg::ModeDateSet: begin
               if (action == cske_pkg::ActNext) begin
                  next_state.date_cursor = (cur_state.date_cursor >= cske_pkg::CurThird) ?
                                           cske_pkg::CurFirst : cur_state.date_cursor + 2'd1;
                  result.changed_item = cske_pkg::ItemCursor;
                  result.new_value = 15'(next_state.date_cursor);
               end else begin
                  result.commit = cske_pkg::CommitClock;
                  if (cur_state.date_cursor == cske_pkg::CurFirst) begin
                     if (inc)
                        next_state.set_year = (cur_state.set_year >= cske_pkg::YearMax) ?
                                              cske_pkg::YearMin : cur_state.set_year + 14'd1;
                     else
                        next_state.set_year = (cur_state.set_year <= cske_pkg::YearMin) ?
                                              cske_pkg::YearMax : cur_state.set_year - 14'd1;
                     result.changed_item = cske_pkg::ItemYear;
                     result.new_value = 15'(next_state.set_year);
                  end else if (cur_state.date_cursor == cske_pkg::CurSecond) begin
                     if (inc)
                        next_state.set_month = (cur_state.set_month >= cske_pkg::MonthMax) ?
                                               4'd1 : cur_state.set_month + 4'd1;
                     else
                        next_state.set_month = (cur_state.set_month <= 4'd1) ?
                                               cske_pkg::MonthMax : cur_state.set_month - 4'd1;
                     result.changed_item = cske_pkg::ItemMonth;
                     result.new_value = 15'(next_state.set_month);
                  end else if (cur_state.date_cursor == cske_pkg::CurThird) begin
                     if (inc)
                        next_state.set_day = (cur_state.set_day >= month_len) ?
                                             5'd1 : cur_state.set_day + 5'd1;
                     else
                        next_state.set_day = (cur_state.set_day <= 5'd1) ?
                                             month_len : cur_state.set_day - 5'd1;
                     result.changed_item = cske_pkg::ItemDay;
                     result.new_value = 15'(next_state.set_day);
                  end
               end
               result.cursor = next_state.date_cursor;
            end
            cske_pkg::ModeZoneSet: begin
               // The offset saturates; a press at the limit changes and commits nothing.
               if (action == cske_pkg::ActDecrease && cur_state.zone_offset > cske_pkg::ZoneMin)
               begin
                  next_state.zone_offset = cur_state.zone_offset - 5'sd1;
                  result.changed_item = cske_pkg::ItemZone;
                  result.new_value = {{10{next_state.zone_offset[4]}}, next_state.zone_offset};
                  result.commit = cske_pkg::CommitZone;
               end else if (inc && cur_state.zone_offset < cske_pkg::ZoneMax) begin
                  next_state.zone_offset = cur_state.zone_offset + 5'sd1;
                  result.changed_item = cske_pkg::ItemZone;
                  result.new_value = {{10{next_state.zone_offset[4]}}, next_state.zone_offset};
                  result.commit = cske_pkg::CommitZone;
               end
            end
            cske_pkg::ModeAlarmSet: begin
               result.commit = cske_pkg::CommitAlarm;
               if (action == cske_pkg::ActNext) begin
                  next_state.alarm_cursor = (cur_state.alarm_cursor >= cske_pkg::CurThird) ?
                                            cske_pkg::CurFirst : cur_state.alarm_cursor + 2'd1;
                  result.changed_item = cske_pkg::ItemCursor;
                  result.new_value = 15'(next_state.alarm_cursor);
               end else if (cur_state.alarm_cursor == cske_pkg::CurFirst) begin
                  if (inc)
                     next_state.alarm_hour = (cur_state.alarm_hour >= cske_pkg::HourTop) ?
                                             5'd0 : cur_state.alarm_hour + 5'd1;
                  else
                     next_state.alarm_hour = (cur_state.alarm_hour == 5'd0 ||
                                              cur_state.alarm_hour > cske_pkg::HourTop) ?
                                             cske_pkg::HourTop : cur_state.alarm_hour - 5'd1;
                  result.changed_item = cske_pkg::ItemAlarmHour;
                  result.new_value = 15'(next_state.alarm_hour);
               end else if (cur_state.alarm_cursor == cske_pkg::CurSecond) begin
                  if (inc)
                     next_state.alarm_minute = (cur_state.alarm_minute >= cske_pkg::MinuteTop) ?
                                               6'd0 : cur_state.alarm_minute + 6'd1;
                  else
                     next_state.alarm_minute = (cur_state.alarm_minute == 6'd0 ||
                                                cur_state.alarm_minute > cske_pkg::MinuteTop) ?
                                               cske_pkg::MinuteTop :
                                               cur_state.alarm_minute - 6'd1;
                  result.changed_item = cske_pkg::ItemAlarmMinute;
                  result.new_value = 15'(next_state.alarm_minute);
               end else if (cur_state.alarm_cursor == cske_pkg::CurThird && !inc) begin
                  // Only the decrease key toggles the enable.
                  next_state.alarm_enable = ~cur_state.alarm_enable;
                  result.changed_item = cske_pkg::ItemAlarmEnable;
                  result.new_value = 15'(next_state.alarm_enable);
               end
               result.cursor = next_state.alarm_cursor;
            end
            cske_pkg::ModeSoundSet: begin
               if (action == cske_pkg::ActNext) begin
                  next_state.sound_enable = ~cur_state.sound_enable;
                  result.changed_item = cske_pkg::ItemSound;
                  result.new_value = 15'(next_state.sound_enable);
                  result.commit = cske_pkg::CommitSound;
               end
            end
            cske_pkg::ModeRinging: begin
               result.alarm_release  = (action == cske_pkg::ActNext);
               result.alarm_suppress = inc;
            end
            default: begin
               // Other modes give only the beep.
            end
         endcase
      end
   end

endmodule

// ===== design/clock_setting_key_editor_top.sv =====
`timescale 1ns / 1ps
// Clock setting key editor: input register, key evaluation, result register.
// Depends on cske_pkg and cske_step.
//
// Usage:
//   The req channel carries one qualified key press: the key code in tdata
//   and the current display mode in tuser. Every press gives exactly one
//   transfer on the rsp channel: the changed item code in tuser, and in
//   tdata its new value, the cursor, the request pulses and the commit code.
//   A req transfer is held in the input register, then passes through the
//   key evaluation into the result register, which drives rsp_tvalid.
//   Throughput is one press per cycle while rsp_tready stays high; the
//   settings registers are read and updated in the same cycle as the press
//   leaves the input register, so the next press sees them at once.
//   Reset returns all settings to their power-up values (time 00:00:00,
//   date 1970-01-01, zone 0, alarm 00:00 off, sound and stopwatch off) and
//   empties both registers. When the receiver holds rsp_tready low, the
//   result stays put, one more press waits in the input register, and
//   req_tready then drops until the result is taken.
module clock_setting_key_editor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [1:0] action, [7:2] zero
   input  logic [2:0]  req_tuser,   // [2:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [14:0] new_value, [16:15] cursor, [17] beep,
                                    // [18] stopwatch_clear, [19] alarm_release,
                                    // [20] alarm_suppress, [21] next_row,
                                    // [24:22] commit, [31:25] zero
   output logic [3:0]  rsp_tuser    // [3:0] changed_item
);

   logic                 in_valid_ff;
   logic [1:0]           action_ff;
   logic [2:0]           mode_ff;
   logic                 out_valid_ff;
   cske_pkg::result_type result_ff;
   cske_pkg::state_type  state_ff;
   cske_pkg::state_type  state_in;
   cske_pkg::result_type result_in;
   logic                 advance;

   // A press moves on when the result register is free or being emptied.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         action_ff <= req_tdata[1:0];
         mode_ff   <= req_tuser;
      end
   end

   cske_step u_step (
      .cur_state  (state_ff),
      .action     (action_ff),
      .mode       (mode_ff),
      .next_state (state_in),
      .result     (result_in)
   );

   // Settings update once per press.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cske_pkg::StateReset;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = result_ff.changed_item;
   assign rsp_tdata  = {7'd0,
                        result_ff.commit,
                        result_ff.next_row,
                        result_ff.alarm_suppress,
                        result_ff.alarm_release,
                        result_ff.stopwatch_clear,
                        result_ff.beep,
                        result_ff.cursor,
                        result_ff.new_value};

endmodule
